FILE: hw/rtl/sso_pkg.sv
package sso_pkg;

  // Shared arithmetic unit widths
  localparam int unsigned MCAND_W  = 64;
  localparam int unsigned MPLIER_W = 40;
  localparam int unsigned PROD_W   = MCAND_W + MPLIER_W;

  // Angle datapath widths
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned CORDIC_W = 34;

  // Default parameter values
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF    = 8;

  // Fixed scale constants
  localparam logic [CORDIC_W-1:0] CORDIC_GAIN   = 34'd652032874;
  localparam logic [MCAND_W-1:0]  YAW_TO_TURN   = 64'd7818173456;
  localparam logic [12:0]         CENTIDEG_RAD  = 13'd5730;

  // Speed ratio (PG << 16) / 960 formed as PG * ceil(2^54 / 15) >> 44,
  // exact for any 40-bit PG
  localparam logic [MCAND_W-1:0]  RPM_RECIP     = 64'd1200959900632133;
  localparam int unsigned         RPM_RECIP_SH  = 44;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIMETER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS    = 4'd3;

  localparam logic [23:0] PERIMETER_RST = 24'd122880;
  localparam logic [15:0] TRACK_RST     = 16'd6400;
  localparam logic [15:0] GEAR_RST      = 16'd3449;
  localparam logic [15:0] COUNTS_RST    = 16'd8192;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/sso_alu.sv
module sso_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sso_pkg::alu_req_t             req_i,
  input  logic [sso_pkg::MCAND_W-1:0]   a_i,
  input  logic [sso_pkg::MPLIER_W-1:0]  b_i,
  output logic                          done_o,
  output logic [sso_pkg::PROD_W-1:0]    res_o
);
  import sso_pkg::*;

  localparam int unsigned CNT_W = $clog2(MCAND_W);

  logic                busy_q;
  logic                done_q;
  alu_op_e             op_q;
  logic [PROD_W-1:0]   acc_q;
  logic [PROD_W-1:0]   mcand_q;
  logic [MPLIER_W-1:0] mplier_q;   // multiplier, or divisor
  logic [MPLIER_W-1:0] rem_q;
  logic [MCAND_W-1:0]  quo_q;
  logic [CNT_W-1:0]    cnt_q;

  logic [MPLIER_W:0]   shifted;
  logic [MPLIER_W+1:0] diff;

  // Restoring divide trial subtract
  assign shifted = {rem_q, quo_q[MCAND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, mplier_q};

  // Shift-add multiply (stops when multiplier runs out), or one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      op_q     <= ALU_MUL;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        op_q     <= req_i.op;
        acc_q    <= '0;
        mcand_q  <= PROD_W'(a_i);
        mplier_q <= b_i;
        rem_q    <= '0;
        quo_q    <= a_i;
        cnt_q    <= '0;
      end else if (busy_q) begin
        unique case (op_q)
          ALU_MUL: begin
            if (mplier_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              if (mplier_q[0]) acc_q <= acc_q + mcand_q;
              mcand_q  <= mcand_q << 1;
              mplier_q <= mplier_q >> 1;
            end
          end
          ALU_DIV: begin
            if (!diff[MPLIER_W+1]) begin
              rem_q <= diff[MPLIER_W-1:0];
              quo_q <= {quo_q[MCAND_W-2:0], 1'b1};
            end else begin
              rem_q <= shifted[MPLIER_W-1:0];
              quo_q <= {quo_q[MCAND_W-2:0], 1'b0};
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_W'(MCAND_W - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ALU_MUL) ? acc_q : PROD_W'(quo_q);

endmodule

FILE: hw/rtl/sso_cordic.sv
module sso_cordic #(
  parameter int unsigned CORDIC_STEPS = sso_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [sso_pkg::PHASE_W-1:0]         phase_i,
  output logic                                done_o,
  output logic signed [sso_pkg::CORDIC_W-1:0] cos_o,
  output logic signed [sso_pkg::CORDIC_W-1:0] sin_o
);
  import sso_pkg::*;

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS + 1);

  logic                       busy_q;
  logic                       done_q;
  logic                       flip_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic signed [CORDIC_W-1:0] cos_q, sin_q;
  logic [CNT_W-1:0]           i_q;

  logic signed [CORDIC_W-1:0] dx, dy, at;
  logic [PHASE_W-1:0]         quarter, folded;
  logic                       flip;

  // Fold into the right half-plane and prepare one rotation step
  always_comb begin
    quarter = phase_i + 32'h4000_0000;
    flip    = quarter[PHASE_W-1];
    folded  = flip ? {~phase_i[PHASE_W-1], phase_i[PHASE_W-2:0]} : phase_i;
    dx      = y_q >>> i_q;
    dy      = x_q >>> i_q;
    at      = signed'({2'b00, atan_turn(5'(i_q))});
  end

  // Rotate one step a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      cos_q  <= '0;
      sin_q  <= '0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        flip_q <= flip;
        x_q    <= signed'(CORDIC_GAIN);
        y_q    <= '0;
        z_q    <= signed'({{(CORDIC_W-PHASE_W){folded[PHASE_W-1]}}, folded});
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == CNT_W'(CORDIC_STEPS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          cos_q  <= flip_q ? -x_q : x_q;
          sin_q  <= flip_q ? -y_q : y_q;
        end else begin
          if (!z_q[CORDIC_W-1]) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + at;
          end
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

FILE: hw/rtl/skid_steer_odometry_unit.sv
// Four-wheel skid-steer odometry.
// Slave stream: one transfer carries four encoder totals, four wheel rpm values
// and the gyro yaw. Master stream: one transfer per input with x, y, wheel
// heading, forward speed and turn rate. Config channel: register index plus
// data, always ready; write only while the block is idle.
// One input is taken at a time; s_axis_tready is high only while idle. Work
// runs on a single shift-add multiply / restoring divide unit and an
// iterative CORDIC. A multiply ends once its multiplier is shifted down to
// zero; an item needs seven multiplies of at most 34 multiplier bits and a
// CORDIC rotation of CORDIC_STEPS steps.
// After reset or any config write, the first item also rebuilds the four
// scale ratios first: four multiplies and three divides.
// Reset clears position, heading and history and loads default registers.
// A result waits in an output register while the receiver stalls; the next
// item is accepted meanwhile and held back only at its own result stage.
module skid_steer_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = sso_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned FRAC_BITS    = sso_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // enc_front_right, enc_front_left, enc_back_left, enc_back_right,
  // rpm_front_right, rpm_front_left, rpm_back_left, rpm_back_right, yaw_centideg
  input  logic [223:0]                     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pos_x, pos_y, heading_centideg, speed_fwd, turn_rate_centideg
  output logic [191:0]                     m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sso_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sso_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sso_pkg::*;

  localparam int unsigned TURN_SH = 24 - FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PG, ST_PGK, ST_CT, ST_FR, ST_TR, ST_VR, ST_WR,
    ST_FWD, ST_TURN, ST_SPD, ST_RATE, ST_PHASE, ST_CORD, ST_PX, ST_PY, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration
  logic [23:0] per_q;
  logic [15:0] trk_q, gear_q, cnt_q;
  logic [15:0] cnt_eff, trk_eff;
  logic [28:0] trk7680;
  logic        ratio_ok_q;

  // Scale ratios and their intermediates
  logic [39:0]        pg_q;
  logic [52:0]        pgk_q;
  logic [31:0]        ct_q;
  logic [MCAND_W-1:0] fr_q, tr_q, vr_q, wr_q;

  // Captured item, as magnitude and sign
  logic [33:0] fmag_q, tmag_q;
  logic [17:0] smag_q, rmag_q;
  logic [31:0] ymag_q;
  logic        fneg_q, tneg_q, sneg_q, rneg_q, yneg_q;

  // Odometry state
  logic [47:0] prev_fwd_q, prev_turn_q, acc_x_q, acc_y_q, acc_h_q;
  logic [47:0] dmag_q;
  logic        dneg_q;
  logic [31:0] spd_q, rate_q;
  logic [CORDIC_W-1:0] cos_q, sin_q;

  logic         m_valid_q;
  logic [191:0] m_data_q;

  // Shared units
  alu_req_t            alu_req;
  logic                alu_go_q, alu_done;
  logic [MCAND_W-1:0]  alu_a;
  logic [MPLIER_W-1:0] alu_b;
  logic [PROD_W-1:0]   alu_res;
  logic                cord_go_q, cord_done;
  logic [PHASE_W-1:0]  phase_q;
  logic signed [CORDIC_W-1:0] cord_cos, cord_sin;

  // Input field unpacking and side sums
  logic [31:0] e_fr, e_fl, e_bl, e_br, yaw;
  logic [15:0] r_fr, r_fl, r_bl, r_br;
  logic [32:0] sl, sr;
  logic [33:0] lr_diff, lr_sum;
  logic [16:0] rl, rr;
  logic [17:0] rpm_diff, rpm_sum;

  // Result extraction
  logic [47:0] fwd_mag, fwd_s, dfwd, turn_mag, turn_s, pstep_mag;
  logic [31:0] spd_mag, rate_mag, ph_mag;
  logic        cneg, sneg_c;
  logic [CORDIC_W-1:0] cmag, smag_c;

  assign e_fr = s_axis_tdata[31:0];
  assign e_fl = s_axis_tdata[63:32];
  assign e_bl = s_axis_tdata[95:64];
  assign e_br = s_axis_tdata[127:96];
  assign r_fr = s_axis_tdata[143:128];
  assign r_fl = s_axis_tdata[159:144];
  assign r_bl = s_axis_tdata[175:160];
  assign r_br = s_axis_tdata[191:176];
  assign yaw  = s_axis_tdata[223:192];

  assign sl       = {e_fl[31], e_fl} + {e_bl[31], e_bl};
  assign sr       = {e_fr[31], e_fr} + {e_br[31], e_br};
  assign lr_diff  = {sl[32], sl} - {sr[32], sr};
  assign lr_sum   = {sl[32], sl} + {sr[32], sr};
  assign rl       = {r_fl[15], r_fl} + {r_bl[15], r_bl};
  assign rr       = {r_fr[15], r_fr} + {r_br[15], r_br};
  assign rpm_diff = {rl[16], rl} - {rr[16], rr};
  assign rpm_sum  = {rl[16], rl} + {rr[16], rr};

  assign cnt_eff = (cnt_q == '0) ? 16'd1 : cnt_q;
  assign trk_eff = (trk_q == '0) ? 16'd1 : trk_q;
  assign trk7680 = {trk_eff, 13'd0} - {4'd0, trk_eff, 9'd0};

  // Pick signed views of the unit's product
  always_comb begin
    fwd_mag   = alu_res[32 +: 48];
    fwd_s     = fneg_q ? 48'd0 - fwd_mag : fwd_mag;
    dfwd      = fwd_s - prev_fwd_q;
    turn_mag  = alu_res[TURN_SH +: 48];
    turn_s    = tneg_q ? 48'd0 - turn_mag : turn_mag;
    spd_mag   = alu_res[32 +: 32];
    rate_mag  = alu_res[24 +: 32];
    ph_mag    = alu_res[16 +: 32];
    pstep_mag = alu_res[30 +: 48];
    cneg      = cos_q[CORDIC_W-1];
    sneg_c    = sin_q[CORDIC_W-1];
    cmag      = cneg ? '0 - cos_q : cos_q;
    smag_c    = sneg_c ? '0 - sin_q : sin_q;
  end

  // Operand selection for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_req.op = ALU_MUL;
    unique case (state_q)
      ST_PG:    begin alu_a = MCAND_W'(per_q);      alu_b = MPLIER_W'(gear_q);    end
      ST_PGK:   begin alu_a = MCAND_W'(pg_q);       alu_b = MPLIER_W'(CENTIDEG_RAD); end
      ST_CT:    begin alu_a = MCAND_W'(cnt_eff);    alu_b = MPLIER_W'(trk_eff);   end
      ST_FR: begin
        alu_req.op = ALU_DIV;
        alu_a = MCAND_W'({pg_q, 16'd0});
        alu_b = MPLIER_W'({cnt_eff, 4'd0});
      end
      ST_TR: begin
        alu_req.op = ALU_DIV;
        alu_a = MCAND_W'({pgk_q, 8'd0});
        alu_b = MPLIER_W'({ct_q, 7'd0});
      end
      ST_VR: begin
        alu_a = RPM_RECIP;
        alu_b = MPLIER_W'(pg_q);
      end
      ST_WR: begin
        alu_req.op = ALU_DIV;
        alu_a = MCAND_W'({pgk_q, 8'd0});
        alu_b = MPLIER_W'(trk7680);
      end
      ST_FWD:   begin alu_a = fr_q;                 alu_b = MPLIER_W'(fmag_q);    end
      ST_TURN:  begin alu_a = tr_q;                 alu_b = MPLIER_W'(tmag_q);    end
      ST_SPD:   begin alu_a = vr_q;                 alu_b = MPLIER_W'(smag_q);    end
      ST_RATE:  begin alu_a = wr_q;                 alu_b = MPLIER_W'(rmag_q);    end
      ST_PHASE: begin alu_a = YAW_TO_TURN;          alu_b = MPLIER_W'(ymag_q);    end
      ST_PX:    begin alu_a = MCAND_W'(dmag_q);     alu_b = MPLIER_W'(cmag);      end
      ST_PY:    begin alu_a = MCAND_W'(dmag_q);     alu_b = MPLIER_W'(smag_c);    end
      default: ;
    endcase
    alu_req.start = alu_go_q;
  end

  sso_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  sso_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_go_q),
    .phase_i (phase_q),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  // Sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      per_q       <= PERIMETER_RST;
      trk_q       <= TRACK_RST;
      gear_q      <= GEAR_RST;
      cnt_q       <= COUNTS_RST;
      ratio_ok_q  <= 1'b0;
      pg_q        <= '0;
      pgk_q       <= '0;
      ct_q        <= '0;
      fr_q        <= '0;
      tr_q        <= '0;
      vr_q        <= '0;
      wr_q        <= '0;
      fmag_q      <= '0;
      tmag_q      <= '0;
      smag_q      <= '0;
      rmag_q      <= '0;
      ymag_q      <= '0;
      fneg_q      <= 1'b0;
      tneg_q      <= 1'b0;
      sneg_q      <= 1'b0;
      rneg_q      <= 1'b0;
      yneg_q      <= 1'b0;
      prev_fwd_q  <= '0;
      prev_turn_q <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_h_q     <= '0;
      dmag_q      <= '0;
      dneg_q      <= 1'b0;
      spd_q       <= '0;
      rate_q      <= '0;
      cos_q       <= '0;
      sin_q       <= '0;
      phase_q     <= '0;
      alu_go_q    <= 1'b0;
      cord_go_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      alu_go_q  <= 1'b0;
      cord_go_q <= 1'b0;

      // Register writes; any write invalidates the cached ratios
      if (cfg_valid_i && cfg_ready_o) begin
        ratio_ok_q <= 1'b0;
        case (cfg_index_i)
          CFG_PERIMETER: per_q  <= cfg_data_i;
          CFG_TRACK:     trk_q  <= cfg_data_i[15:0];
          CFG_GEAR:      gear_q <= cfg_data_i[15:0];
          CFG_COUNTS:    cnt_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // Drop a result once the receiver takes it, unless the next one replaces it
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) m_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            fneg_q   <= lr_diff[33];
            fmag_q   <= lr_diff[33] ? 34'd0 - lr_diff : lr_diff;
            tneg_q   <= !lr_sum[33];
            tmag_q   <= lr_sum[33] ? 34'd0 - lr_sum : lr_sum;
            sneg_q   <= rpm_diff[17];
            smag_q   <= rpm_diff[17] ? 18'd0 - rpm_diff : rpm_diff;
            rneg_q   <= !rpm_sum[17];
            rmag_q   <= rpm_sum[17] ? 18'd0 - rpm_sum : rpm_sum;
            yneg_q   <= yaw[31];
            ymag_q   <= yaw[31] ? 32'd0 - yaw : yaw;
            state_q  <= ratio_ok_q ? ST_FWD : ST_PG;
            alu_go_q <= 1'b1;
          end
        end
        ST_PG: if (alu_done) begin
          pg_q <= alu_res[39:0];
          state_q <= ST_PGK;
          alu_go_q <= 1'b1;
        end
        ST_PGK: if (alu_done) begin
          pgk_q <= alu_res[52:0];
          state_q <= ST_CT;
          alu_go_q <= 1'b1;
        end
        ST_CT: if (alu_done) begin
          ct_q <= alu_res[31:0];
          state_q <= ST_FR;
          alu_go_q <= 1'b1;
        end
        ST_FR: if (alu_done) begin
          fr_q <= alu_res[MCAND_W-1:0];
          state_q <= ST_TR;
          alu_go_q <= 1'b1;
        end
        ST_TR: if (alu_done) begin
          tr_q <= alu_res[MCAND_W-1:0];
          state_q <= ST_VR;
          alu_go_q <= 1'b1;
        end
        ST_VR: if (alu_done) begin
          vr_q <= MCAND_W'(alu_res[PROD_W-1:RPM_RECIP_SH]);
          state_q <= ST_WR;
          alu_go_q <= 1'b1;
        end
        ST_WR: if (alu_done) begin
          wr_q <= alu_res[MCAND_W-1:0];
          ratio_ok_q <= 1'b1;
          state_q <= ST_FWD;
          alu_go_q <= 1'b1;
        end
        ST_FWD: if (alu_done) begin
          prev_fwd_q <= fwd_s;
          dneg_q     <= dfwd[47];
          dmag_q     <= dfwd[47] ? 48'd0 - dfwd : dfwd;
          state_q    <= ST_TURN;
          alu_go_q   <= 1'b1;
        end
        ST_TURN: if (alu_done) begin
          prev_turn_q <= turn_s;
          acc_h_q     <= acc_h_q + turn_s - prev_turn_q;
          state_q     <= ST_SPD;
          alu_go_q    <= 1'b1;
        end
        ST_SPD: if (alu_done) begin
          spd_q    <= sneg_q ? 32'd0 - spd_mag : spd_mag;
          state_q  <= ST_RATE;
          alu_go_q <= 1'b1;
        end
        ST_RATE: if (alu_done) begin
          rate_q   <= rneg_q ? 32'd0 - rate_mag : rate_mag;
          state_q  <= ST_PHASE;
          alu_go_q <= 1'b1;
        end
        ST_PHASE: if (alu_done) begin
          phase_q   <= yneg_q ? 32'd0 - ph_mag : ph_mag;
          state_q   <= ST_CORD;
          cord_go_q <= 1'b1;
        end
        ST_CORD: if (cord_done) begin
          cos_q    <= cord_cos;
          sin_q    <= cord_sin;
          state_q  <= ST_PX;
          alu_go_q <= 1'b1;
        end
        ST_PX: if (alu_done) begin
          acc_x_q  <= (dneg_q ^ cneg) ? acc_x_q - pstep_mag : acc_x_q + pstep_mag;
          state_q  <= ST_PY;
          alu_go_q <= 1'b1;
        end
        ST_PY: if (alu_done) begin
          acc_y_q <= (dneg_q ^ sneg_c) ? acc_y_q - pstep_mag : acc_y_q + pstep_mag;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {rate_q, spd_q, acc_h_q[FRAC_BITS +: 32], acc_y_q, acc_x_q};
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  // An accepted item keeps the input closed on the next cycle
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still open after a transfer");

  // The shared unit only finishes while a step waits on it
  a_alu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_CORD))
    else $error("arithmetic result with no step waiting");

  // A stalled pending result keeps the next one at the result stage
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_axis_tvalid && !m_axis_tready)
      |=> (state_q == ST_OUT && m_axis_tvalid))
    else $error("result stage advanced over a stalled output");

endmodule

FILE: sim/skid_steer_odometry_unit_test.sv
module skid_steer_odometry_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sso_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned ROT_STEPS = CORDIC_STEPS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd9;
  localparam bit [63:0] PHASE_SCALE = 64'd7818173456;
  localparam bit [63:0] ROT_GAIN = 64'd652032874;

  typedef struct packed {
    logic [31:0] yaw;
    logic [15:0] rpm_br, rpm_bl, rpm_fl, rpm_fr;
    logic [31:0] enc_br, enc_bl, enc_fl, enc_fr;
  } wheel_sample_t;

  typedef struct packed {
    logic [31:0] rate;
    logic [31:0] speed;
    logic [31:0] heading;
    logic [47:0] pos_y;
    logic [47:0] pos_x;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  skid_steer_odometry_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Pending samples, expected poses, shadow registers and shadow odometry state
  wheel_sample_t sample_q[$];
  pose_t pose_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_epoch = 0;
  logic in_xfer_q = 1'b0;

  bit [63:0] perim_r = 64'd122880, track_r = 64'd6400, gear_r = 64'd3449, counts_r = 64'd8192;
  bit [47:0] last_fwd = '0, last_turn = '0, x_acc = '0, y_acc = '0, head_acc = '0;

  bit [31:0] arctan_turn [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Signed multiply, shift right with the magnitude truncated toward zero
  function automatic bit [63:0] mul_trunc(input bit [63:0] a, input bit [63:0] b,
                                          input int sh);
    bit [63:0] ma, mb, r;
    bit [127:0] p;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = {64'b0, ma} * {64'b0, mb};
    p = p >> sh;
    r = p[63:0];
    return (a[63] != b[63]) ? -r : r;
  endfunction

  function automatic bit [63:0] shr_arith(input bit [63:0] v, input int sh);
    bit signed [63:0] t;
    t = v;
    return t >>> sh;
  endfunction

  // Gyro yaw to cosine and sine, both Q30
  task automatic yaw_sincos(input bit [31:0] yaw, output bit [63:0] c, output bit [63:0] s);
    bit [63:0] ph, x, y, z, dx, dy;
    bit flip;
    ph = mul_trunc({{32{yaw[31]}}, yaw}, PHASE_SCALE, 16) & 64'hFFFF_FFFF;
    flip = ph[31] ^ ph[30];
    if (flip) ph = (ph - 64'h8000_0000) & 64'hFFFF_FFFF;
    z = {{32{ph[31]}}, ph[31:0]};
    x = ROT_GAIN;
    y = '0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = shr_arith(y, i);
      dy = shr_arith(x, i);
      if (!z[63]) begin
        x -= dx; y += dy; z -= arctan_turn[i];
      end else begin
        x += dx; y -= dy; z += arctan_turn[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Advance the shadow odometry by one sample and return the pose it yields
  task automatic advance_pose(input wheel_sample_t w, output pose_t p);
    bit [63:0] cnt, trk, pg, fr, tr, vr, wr, sr, sl, rr, rl, fwd, turn, dfwd, c, s, t;
    bit [47:0] d48;
    cnt = counts_r ? counts_r : 64'd1;
    trk = track_r ? track_r : 64'd1;
    pg = perim_r * gear_r;
    fr = (pg << 16) / (64'd16 * cnt);
    tr = ((pg * 64'd5730) << 8) / (64'd128 * cnt * trk);
    vr = (pg << 16) / 64'd960;
    wr = ((pg * 64'd5730) << 8) / (64'd7680 * trk);
    sr = {{32{w.enc_fr[31]}}, w.enc_fr} + {{32{w.enc_br[31]}}, w.enc_br};
    sl = {{32{w.enc_fl[31]}}, w.enc_fl} + {{32{w.enc_bl[31]}}, w.enc_bl};
    rr = {{48{w.rpm_fr[15]}}, w.rpm_fr} + {{48{w.rpm_br[15]}}, w.rpm_br};
    rl = {{48{w.rpm_fl[15]}}, w.rpm_fl} + {{48{w.rpm_bl[15]}}, w.rpm_bl};
    fwd = mul_trunc(sl - sr, fr, 32);
    turn = mul_trunc(-(sl + sr), tr, 24 - FRAC);
    d48 = fwd[47:0] - last_fwd;
    dfwd = {{16{d48[47]}}, d48};
    head_acc = head_acc + (turn[47:0] - last_turn);
    last_fwd = fwd[47:0];
    last_turn = turn[47:0];
    yaw_sincos(w.yaw, c, s);
    t = mul_trunc(dfwd, c, 30);
    x_acc = x_acc + t[47:0];
    t = mul_trunc(dfwd, s, 30);
    y_acc = y_acc + t[47:0];
    p.pos_x = x_acc;
    p.pos_y = y_acc;
    p.heading = head_acc[FRAC +: 32];
    t = mul_trunc(rl - rr, vr, 32);
    p.speed = t[31:0];
    t = mul_trunc(-(rl + rr), wr, 24);
    p.rate = t[31:0];
  endtask

  // Record input transfers and predict their poses
  always @(posedge clk_i) begin
    pose_t p;
    in_xfer_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      advance_pose(wheel_sample_t'(s_axis_tdata), p);
      pose_q.push_back(p);
    end
  end

  // Sample driver: offer the next sample once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_xfer_q)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    int hold_left;
    int seen_epoch;
    if (hold_epoch != seen_epoch) begin
      seen_epoch = hold_epoch;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Pose monitor
  always @(posedge clk_i) begin
    pose_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pose_q.size() == 0) begin
        report("unexpected pose", 64'(got.pos_x), 64'd0);
      end else begin
        want = pose_q.pop_front();
        if (got.pos_x !== want.pos_x) report("pos_x", 64'(got.pos_x), 64'(want.pos_x));
        if (got.pos_y !== want.pos_y) report("pos_y", 64'(got.pos_y), 64'(want.pos_y));
        if (got.heading !== want.heading)
          report("heading", 64'(got.heading), 64'(want.heading));
        if (got.speed !== want.speed) report("speed_fwd", 64'(got.speed), 64'(want.speed));
        if (got.rate !== want.rate) report("turn_rate", 64'(got.rate), 64'(want.rate));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PERIMETER: perim_r = 64'(val);
      CFG_TRACK: track_r = 64'(val[15:0]);
      CFG_GEAR: gear_r = 64'(val[15:0]);
      CFG_COUNTS: counts_r = 64'(val[15:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [23:0] pm, input logic [15:0] tk,
                          input logic [15:0] gr, input logic [15:0] ct);
    write_reg(CFG_PERIMETER, pm);
    write_reg(CFG_TRACK, 24'(tk));
    write_reg(CFG_GEAR, 24'(gr));
    write_reg(CFG_COUNTS, 24'(ct));
  endtask

  task automatic drain();
    do @(posedge clk_i); while (sample_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_sample(input logic [31:0] fr, input logic [31:0] fl,
                            input logic [31:0] bl, input logic [31:0] br,
                            input logic [15:0] rpm, input logic [31:0] yaw);
    wheel_sample_t w;
    w.enc_fr = fr; w.enc_fl = fl; w.enc_bl = bl; w.enc_br = br;
    w.rpm_fr = rpm; w.rpm_fl = ~rpm; w.rpm_bl = rpm; w.rpm_br = -rpm;
    w.yaw = yaw;
    sample_q.push_back(w);
  endtask

  // Mostly a drive with small encoder steps, some full-range noise
  task automatic add_random(input int n);
    wheel_sample_t w;
    logic [31:0] base [4];
    for (int k = 0; k < 4; k++) base[k] = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        for (int k = 0; k < 4; k++) base[k] += $urandom_range(4000) - 2000;
        {w.enc_br, w.enc_bl, w.enc_fl, w.enc_fr} = {base[3], base[2], base[1], base[0]};
        w.rpm_fr = 16'($urandom_range(600) - 300);
        w.rpm_fl = 16'($urandom_range(600) - 300);
        w.rpm_bl = 16'($urandom_range(600) - 300);
        w.rpm_br = 16'($urandom_range(600) - 300);
        w.yaw = $urandom_range(3) == 0 ? $urandom : $urandom_range(72000) - 36000;
      end
      sample_q.push_back(w);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, quadrant yaws, first step after reset
    add_sample(32'd1000, 32'd2000, 32'd2000, 32'd1000, 16'd100, 32'd0);
    add_sample(32'd1500, 32'd2600, 32'd2600, 32'd1500, 16'd100, 32'd9000);
    add_sample(32'd1500, 32'd3600, 32'd3600, 32'd1500, 16'd0, 32'd18000);
    add_sample(32'd1500, 32'd4600, 32'd4600, 32'd1500, 16'd0, -32'd18000);
    add_sample(32'd1500, 32'd5600, 32'd5600, 32'd1500, 16'h7FFF, 32'd27000);
    add_sample(32'd1500, 32'd6600, 32'd6600, 32'd1500, 16'h8000, -32'd9000);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF,
               32'h7FFF_FFFF);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF,
               32'h8000_0000);
    add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 32'd4500);
    add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd1, 32'd13500);
    add_sample(32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
    add_sample(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 16'hFFFF, -32'd1);
    drain();

    // Wrapping speeds and rate at the largest scale, then the smallest
    set_regs(24'hFF_FFFF, 16'd1, 16'hFFFF, 16'd1);
    add_sample(32'd5, 32'd100, 32'd90, 32'd7, 16'h7FFF, 32'd3000);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 32'd100);
    add_random(250);
    drain();
    set_regs(24'd1, 16'hFFFF, 16'd1, 16'hFFFF);
    send_idle_pct = 57;
    add_random(280);
    drain();

    // Zero counts and track are taken as one; unmapped index is ignored
    set_regs(24'd122880, 16'd0, 16'd3449, 16'd0);
    write_reg(CFG_UNMAPPED, 24'h123456);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    add_random(280);
    drain();

    set_regs(24'd122880, 16'd6400, 16'd3449, 16'd8192);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    add_random(280);
    drain();

    // Long receiver hold-off while samples keep coming
    set_regs(24'($urandom_range(24'hFF_FFFF, 1)), 16'($urandom_range(16'hFFFF, 1)),
             16'($urandom_range(16'hFFFF, 1)), 16'($urandom_range(16'hFFFF, 1)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_epoch++;
    add_random(300);
    drain();

    set_regs(24'($urandom_range(24'hFF_FFFF, 1)), 16'($urandom_range(16'hFFFF, 1)),
             16'($urandom_range(16'hFFFF, 1)), 16'($urandom_range(16'hFFFF, 1)));
    send_idle_pct = 57;
    recv_stall_pct = 57;
    add_random(280);
    drain();
    repeat (600) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb: failure");
    $finish;
  end

endmodule
